// File: rtl/sfsr_pkg.sv
// ----------------------------------------------------------------------------
// sfsr_pkg
// Shared types, codes and constants of the stepper flow speed ramp.
// ----------------------------------------------------------------------------
package sfsr_pkg;

  localparam int DIV_W = 40;
  localparam int CNT_W = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_SPEED,
    ST_CLAMP,
    ST_MUL,
    ST_STEP,
    ST_RAMP,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_RAMP_EN    = 3'd0;
  localparam logic [2:0] REG_RESUME     = 3'd1;
  localparam logic [2:0] REG_INTERVAL   = 3'd2;
  localparam logic [2:0] REG_STEP_RPM   = 3'd3;
  localparam logic [2:0] REG_ONE_RPM    = 3'd4;
  localparam logic [2:0] REG_FLOW_NUM   = 3'd5;

  localparam logic        RST_RAMP_EN  = 1'b1;
  localparam logic        RST_RESUME   = 1'b0;
  localparam logic [15:0] RST_INTERVAL = 16'd100;
  localparam logic [8:0]  RST_STEP_RPM = 9'd50;
  localparam logic [31:0] RST_ONE_RPM  = 32'd1800000;
  localparam logic [31:0] RST_FLOW_NUM = 32'd144000000;

  localparam logic [16:0] RPM_LIMIT_Q8  = 17'd102400;
  localparam logic [16:0] DIRECT_MAX_Q8 = 17'd12800;
  localparam int          RESUME_DIV_Q8 = 12800;
  localparam int          RESUME_STEPS  = 10;
  localparam logic [9:0]  STEP_MAX      = 10'd1023;
  localparam logic [31:0] RPM_LIMIT     = 32'd400;

  localparam int OUT_LOAD_BIT = 0;
  localparam int OUT_STOP_BIT = 33;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [9:0] resume_step(input logic [16:0] rpm);
    logic [9:0] n;
    n = 10'd0;
    for (int k = 1; k <= RESUME_STEPS; k++) begin
      if (rpm >= 17'(k * RESUME_DIV_Q8)) begin
        n = n + 10'd1;
      end
    end
    return n;
  endfunction

endpackage

// File: rtl/stepper_flow_speed_ramp_top.sv
// ----------------------------------------------------------------------------
// stepper_flow_speed_ramp_top
// Flow rate to stepper timer period conversion with a linear speed ramp.
// ----------------------------------------------------------------------------
// One item is taken at a time and every item gives one result beat. All
// quotients come from one bit-serial divider. A start beat with a nonzero
// flow makes two passes (period, then speed) and a third when the speed
// clamps at 400 rpm. A tick that runs a ramp step makes one pass after a
// registered 10x9 product, unless a ramp-up has reached its target. A new
// beat is taken while the last result still waits at the output register.
module stepper_flow_speed_ramp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // flow_rate
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  // timer_load, timer_period, motor_stop, ramp_up_active, ramp_down_active,
  // target_speed, zero fill
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfsr_pkg::state_t   state, state_next;
  sfsr_pkg::div_req_t div_req;
  sfsr_pkg::div_rsp_t div_rsp;

  logic        ramp_enable;
  logic        resume_from_last;
  logic [15:0] ramp_interval_ms;
  logic [8:0]  ramp_step_rpm;
  logic [31:0] one_rpm_period;
  logic [31:0] flow_period_numerator;

  logic [31:0] target_period, target_period_next;
  logic [16:0] target_rpm, target_rpm_next;
  logic [9:0]  step_count, step_count_next;
  logic        ramping_up, ramping_up_next;
  logic        ramping_down, ramping_down_next;
  logic [15:0] interval_count, interval_count_next;

  logic        res_load, res_load_next;
  logic [31:0] res_period, res_period_next;
  logic        res_stop, res_stop_next;
  logic [31:0] period_r, period_r_next;
  logic [18:0] prod_r, prod_r_next;
  logic        m_tvalid_next;
  logic [55:0] m_tdata_next;

  logic [15:0] ic_dec;
  logic        over;
  logic [16:0] rpm_clamped;
  logic [31:0] q_sat;
  logic        cfg_wr;

  sfsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == sfsr_pkg::ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    ic_dec      = (interval_count != 16'd0) ? interval_count - 16'd1 : interval_count;
    over        = (|div_rsp.quotient[sfsr_pkg::DIV_W-1:17]) ||
                  (div_rsp.quotient[16:0] > sfsr_pkg::RPM_LIMIT_Q8);
    rpm_clamped = over ? sfsr_pkg::RPM_LIMIT_Q8 : div_rsp.quotient[16:0];
    q_sat       = (|div_rsp.quotient[sfsr_pkg::DIV_W-1:32]) ? 32'hFFFF_FFFF
                                                            : div_rsp.quotient[31:0];
  end

  always_comb begin
    state_next          = state;
    target_period_next  = target_period;
    target_rpm_next     = target_rpm;
    step_count_next     = step_count;
    ramping_up_next     = ramping_up;
    ramping_down_next   = ramping_down;
    interval_count_next = interval_count;
    res_load_next       = res_load;
    res_period_next     = res_period;
    res_stop_next       = res_stop;
    period_r_next       = period_r;
    prod_r_next         = prod_r;
    m_tdata_next        = m_tdata;
    m_tvalid_next       = m_tvalid && !m_tready;
    div_req             = '0;

    case (state)
      sfsr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          res_load_next   = 1'b0;
          res_period_next = 32'd0;
          res_stop_next   = 1'b0;
          state_next      = sfsr_pkg::ST_OUT;
          case (sfsr_pkg::cmd_t'(s_tuser))
            sfsr_pkg::CMD_START: begin
              if (s_tdata == 16'd0) begin
                res_stop_next      = 1'b1;
                ramping_up_next    = 1'b0;
                ramping_down_next  = 1'b0;
                step_count_next    = 10'd0;
                target_rpm_next    = 17'd0;
                target_period_next = 32'd0;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = sfsr_pkg::DIV_W'(flow_period_numerator);
                div_req.divisor  = 32'(s_tdata);
                state_next       = sfsr_pkg::ST_PERIOD;
              end
            end
            sfsr_pkg::CMD_TICK: begin
              interval_count_next = ic_dec;
              if (ic_dec == 16'd0 && (ramping_up || ramping_down)) begin
                interval_count_next = ramp_interval_ms;
                if (ramping_up) begin
                  if (step_count != sfsr_pkg::STEP_MAX) begin
                    step_count_next = step_count + 10'd1;
                  end
                  state_next = sfsr_pkg::ST_MUL;
                end else if (step_count != 10'd0) begin
                  state_next = sfsr_pkg::ST_MUL;
                end else begin
                  res_stop_next     = 1'b1;
                  ramping_down_next = 1'b0;
                end
              end
            end
            sfsr_pkg::CMD_STOP: begin
              ramping_up_next   = 1'b0;
              ramping_down_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      sfsr_pkg::ST_PERIOD: begin
        if (div_rsp.done) begin
          period_r_next    = div_rsp.quotient[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = {one_rpm_period, 8'd0};
          div_req.divisor  = div_rsp.quotient[31:0];
          state_next       = sfsr_pkg::ST_SPEED;
        end
      end

      sfsr_pkg::ST_SPEED: begin
        if (div_rsp.done) begin
          target_rpm_next   = rpm_clamped;
          ramping_down_next = 1'b0;
          if (over) begin
            div_req.start    = 1'b1;
            div_req.dividend = sfsr_pkg::DIV_W'(one_rpm_period);
            div_req.divisor  = sfsr_pkg::RPM_LIMIT;
            state_next       = sfsr_pkg::ST_CLAMP;
          end else begin
            target_period_next = period_r;
            state_next         = sfsr_pkg::ST_OUT;
          end
          if (rpm_clamped <= sfsr_pkg::DIRECT_MAX_Q8 || !ramp_enable) begin
            res_load_next   = 1'b1;
            res_period_next = period_r;
            ramping_up_next = 1'b0;
          end else begin
            ramping_up_next = 1'b1;
            step_count_next = resume_from_last ? sfsr_pkg::resume_step(target_rpm)
                                               : 10'd0;
          end
        end
      end

      sfsr_pkg::ST_CLAMP: begin
        if (div_rsp.done) begin
          target_period_next = div_rsp.quotient[31:0];
          state_next         = sfsr_pkg::ST_OUT;
        end
      end

      sfsr_pkg::ST_MUL: begin
        prod_r_next = {9'd0, step_count} * {10'd0, ramp_step_rpm};
        state_next  = sfsr_pkg::ST_STEP;
      end

      sfsr_pkg::ST_STEP: begin
        if (ramping_up) begin
          if ({prod_r, 8'd0} < 27'(target_rpm)) begin
            div_req.start    = 1'b1;
            div_req.dividend = sfsr_pkg::DIV_W'(one_rpm_period);
            div_req.divisor  = 32'(prod_r);
            state_next       = sfsr_pkg::ST_RAMP;
          end else begin
            res_load_next   = 1'b1;
            res_period_next = target_period;
            ramping_up_next = 1'b0;
            state_next      = sfsr_pkg::ST_OUT;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = sfsr_pkg::DIV_W'(one_rpm_period);
          div_req.divisor  = 32'(prod_r);
          step_count_next  = step_count - 10'd1;
          state_next       = sfsr_pkg::ST_RAMP;
        end
      end

      sfsr_pkg::ST_RAMP: begin
        if (div_rsp.done) begin
          res_load_next   = 1'b1;
          res_period_next = q_sat;
          state_next      = sfsr_pkg::ST_OUT;
        end
      end

      sfsr_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {3'd0, target_rpm, ramping_down, ramping_up,
                           res_stop, res_period, res_load};
          state_next    = sfsr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sfsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sfsr_pkg::ST_IDLE;
      target_period  <= 32'd0;
      target_rpm     <= 17'd0;
      step_count     <= 10'd0;
      ramping_up     <= 1'b0;
      ramping_down   <= 1'b0;
      interval_count <= 16'd0;
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      target_period  <= target_period_next;
      target_rpm     <= target_rpm_next;
      step_count     <= step_count_next;
      ramping_up     <= ramping_up_next;
      ramping_down   <= ramping_down_next;
      interval_count <= interval_count_next;
      m_tvalid       <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_load   <= res_load_next;
    res_period <= res_period_next;
    res_stop   <= res_stop_next;
    period_r   <= period_r_next;
    prod_r     <= prod_r_next;
    m_tdata    <= m_tdata_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_enable           <= sfsr_pkg::RST_RAMP_EN;
      resume_from_last      <= sfsr_pkg::RST_RESUME;
      ramp_interval_ms      <= sfsr_pkg::RST_INTERVAL;
      ramp_step_rpm         <= sfsr_pkg::RST_STEP_RPM;
      one_rpm_period        <= sfsr_pkg::RST_ONE_RPM;
      flow_period_numerator <= sfsr_pkg::RST_FLOW_NUM;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        sfsr_pkg::REG_RAMP_EN:  ramp_enable           <= pwdata[0];
        sfsr_pkg::REG_RESUME:   resume_from_last      <= pwdata[0];
        sfsr_pkg::REG_INTERVAL: ramp_interval_ms      <= pwdata[15:0];
        sfsr_pkg::REG_STEP_RPM: ramp_step_rpm         <= pwdata[8:0];
        sfsr_pkg::REG_ONE_RPM:  one_rpm_period        <= pwdata;
        sfsr_pkg::REG_FLOW_NUM: flow_period_numerator <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      sfsr_pkg::REG_RAMP_EN:  prdata = 32'(ramp_enable);
      sfsr_pkg::REG_RESUME:   prdata = 32'(resume_from_last);
      sfsr_pkg::REG_INTERVAL: prdata = 32'(ramp_interval_ms);
      sfsr_pkg::REG_STEP_RPM: prdata = 32'(ramp_step_rpm);
      sfsr_pkg::REG_ONE_RPM:  prdata = one_rpm_period;
      sfsr_pkg::REG_FLOW_NUM: prdata = flow_period_numerator;
      default:                prdata = 32'd0;
    endcase
  end

`ifndef SYNTHESIS
  a_ramp_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ramping_up && ramping_down))
    else $error("ramp up and ramp down both active");

  a_rpm_limit: assert property (@(posedge clk) disable iff (rst)
    target_rpm <= sfsr_pkg::RPM_LIMIT_Q8)
    else $error("target speed above limit");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == sfsr_pkg::ST_PERIOD || state == sfsr_pkg::ST_SPEED ||
                      state == sfsr_pkg::ST_CLAMP || state == sfsr_pkg::ST_RAMP))
    else $error("divider result with no pass waiting");

  a_beat_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == sfsr_pkg::ST_OUT)
    else $error("result beat raised outside output state");

  a_load_or_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[sfsr_pkg::OUT_LOAD_BIT] && m_tdata[sfsr_pkg::OUT_STOP_BIT]))
    else $error("timer load and stop in one beat");
`endif

endmodule

// File: rtl/sfsr_div.sv
// ----------------------------------------------------------------------------
// sfsr_div
// Bit-serial restoring divider: one quotient bit per cycle, 40 bits.
// ----------------------------------------------------------------------------
module sfsr_div (
  input  logic                clk,
  input  logic                rst,
  input  sfsr_pkg::div_req_t  req,
  output sfsr_pkg::div_rsp_t  rsp
);

  logic                       busy;
  logic                       done;
  logic [sfsr_pkg::CNT_W-1:0] cnt;
  logic [31:0]                rem;
  logic [sfsr_pkg::DIV_W-1:0] dq;
  logic [31:0]                dv;
  logic [32:0]                trial;
  logic [32:0]                diff;
  logic                       ge;

  always_comb begin
    trial = {rem, dq[sfsr_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dv};
    diff  = trial - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= sfsr_pkg::CNT_W'(sfsr_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - sfsr_pkg::CNT_W'(1);
        if (cnt == sfsr_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      dq  <= req.dividend;
      dv  <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      dq  <= {dq[sfsr_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the stepper flow speed ramp. Start, tick, stop and
// unused command beats go in through the slave stream. Each beat accepted
// there runs through an in-bench ramp predictor, and the timer update that
// comes out of the master stream is compared field by field. The APB port
// sets several register settings, extremes among them, between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfsr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] flow;
  } motor_cmd_t;

  typedef struct packed {
    logic        load;
    logic [31:0] period;
    logic        halt;
    logic        up;
    logic        down;
    logic [16:0] speed;
  } timer_update_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // flow_rate
  logic [1:0]  s_tuser = '0;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // timer_load, timer_period, motor_stop, ramp_up_active, ramp_down_active,
  // target_speed, zero fill
  logic [55:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  motor_cmd_t    motor_cmds_due[$];
  timer_update_t timer_updates_due[$];

  // register copy
  logic        cfg_ramp_en  = RST_RAMP_EN;
  logic        cfg_resume   = RST_RESUME;
  logic [15:0] cfg_interval = RST_INTERVAL;
  logic [8:0]  cfg_step_rpm = RST_STEP_RPM;
  logic [31:0] cfg_one_rpm  = RST_ONE_RPM;
  logic [31:0] cfg_flow_num = RST_FLOW_NUM;

  // ramp state
  logic [31:0] tgt_period = '0;
  logic [16:0] tgt_rpm = '0;
  logic [9:0]  step_cnt = '0;
  logic        ramping_up = 1'b0;
  logic        ramping_down = 1'b0;
  logic [15:0] tick_cnt = '0;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done;
  int   hold_left;
  int   beats_queued = 0;
  int   settings_used = 0;
  int   results_checked = 0;
  int   loads_seen = 0;
  int   halts_seen = 0;
  int   mismatches = 0;
  int   cycles = 0;

  stepper_flow_speed_ramp_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] sat_div(logic [63:0] n, logic [63:0] d);
    if (d == 64'd0) return '1;
    if (n / d > 64'hFFFF_FFFF) return '1;
    return 32'(n / d);
  endfunction

  function automatic timer_update_t predict_timer_update(cmd_t cmd, logic [15:0] flow);
    timer_update_t r;
    logic [31:0]   period;
    logic [31:0]   rq8;
    logic [31:0]   prod;
    logic [16:0]   prev;
    r = '0;
    case (cmd)
      CMD_START: begin
        if (flow == 16'd0) begin
          r.halt = 1'b1;
          ramping_up = 1'b0;
          ramping_down = 1'b0;
          step_cnt = '0;
          tgt_rpm = '0;
          tgt_period = '0;
        end else begin
          prev = tgt_rpm;
          period = cfg_flow_num / {16'd0, flow};
          rq8 = (period == 32'd0) ? '1 :
                sat_div({24'd0, cfg_one_rpm, 8'd0}, {32'd0, period});
          tgt_period = period;
          if (rq8 > {15'd0, RPM_LIMIT_Q8}) begin
            rq8 = {15'd0, RPM_LIMIT_Q8};
            tgt_period = cfg_one_rpm / RPM_LIMIT;
          end
          tgt_rpm = rq8[16:0];
          ramping_down = 1'b0;
          if (rq8 <= {15'd0, DIRECT_MAX_Q8} || !cfg_ramp_en) begin
            r.load = 1'b1;
            r.period = period;
            ramping_up = 1'b0;
          end else begin
            ramping_up = 1'b1;
            step_cnt = cfg_resume ? 10'(prev / RESUME_DIV_Q8) : 10'd0;
          end
        end
      end
      CMD_TICK: begin
        if (tick_cnt != 16'd0) tick_cnt = tick_cnt - 16'd1;
        if (tick_cnt == 16'd0 && (ramping_up || ramping_down)) begin
          tick_cnt = cfg_interval;
          if (ramping_up) begin
            if (step_cnt < STEP_MAX) step_cnt = step_cnt + 10'd1;
            prod = {22'd0, step_cnt} * {23'd0, cfg_step_rpm};
            r.load = 1'b1;
            if ({24'd0, prod, 8'd0} < {47'd0, tgt_rpm}) begin
              r.period = sat_div({32'd0, cfg_one_rpm}, {32'd0, prod});
            end else begin
              r.period = tgt_period;
              ramping_up = 1'b0;
            end
          end else if (step_cnt != 10'd0) begin
            prod = {22'd0, step_cnt} * {23'd0, cfg_step_rpm};
            r.load = 1'b1;
            r.period = sat_div({32'd0, cfg_one_rpm}, {32'd0, prod});
            step_cnt = step_cnt - 10'd1;
          end else begin
            r.halt = 1'b1;
            ramping_down = 1'b0;
          end
        end
      end
      CMD_STOP: begin
        ramping_up = 1'b0;
        ramping_down = 1'b1;
      end
      default: begin
      end
    endcase
    r.up = ramping_up;
    r.down = ramping_down;
    r.speed = tgt_rpm;
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RAMP_EN:  cfg_ramp_en = value[0];
      REG_RESUME:   cfg_resume = value[0];
      REG_INTERVAL: cfg_interval = value[15:0];
      REG_STEP_RPM: cfg_step_rpm = value[8:0];
      REG_ONE_RPM:  cfg_one_rpm = value;
      REG_FLOW_NUM: cfg_flow_num = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_ramp_config(logic en, logic resume, logic [15:0] interval,
                                 logic [8:0] step_rpm, logic [31:0] one_rpm,
                                 logic [31:0] flow_num);
    reg_write(REG_RAMP_EN, {31'd0, en});
    reg_write(REG_RESUME, {31'd0, resume});
    reg_write(REG_INTERVAL, {16'd0, interval});
    reg_write(REG_STEP_RPM, {23'd0, step_rpm});
    reg_write(REG_ONE_RPM, one_rpm);
    reg_write(REG_FLOW_NUM, flow_num);
    settings_used++;
  endtask

  task automatic add_beat(cmd_t cmd, logic [15:0] flow);
    motor_cmd_t b;
    b.cmd = cmd;
    b.flow = flow;
    motor_cmds_due.push_back(b);
    beats_queued++;
  endtask

  task automatic add_ticks(int n);
    repeat (n) add_beat(CMD_TICK, 16'($urandom));
  endtask

  // start, ramp for a while, often stop and ramp down; some noise between runs
  task automatic add_ramp_runs(int n);
    int          goal;
    logic [15:0] flow;
    goal = beats_queued + n;
    while (beats_queued < goal) begin
      case ($urandom_range(9))
        0: add_beat(CMD_NONE, 16'($urandom));
        1: add_beat(CMD_START, 16'd0);
        2: add_beat(cmd_t'($urandom_range(3)), 16'($urandom));
        default: begin
          case ($urandom_range(3))
            0: flow = 16'($urandom);
            1: flow = 16'($urandom_range(1, 4000));
            2: flow = 16'($urandom_range(4001, 40000));
            default: flow = $urandom_range(1) ? 16'hFFFF : 16'd1;
          endcase
          add_beat(CMD_START, flow);
          add_ticks($urandom_range(30));
          if ($urandom_range(1)) begin
            add_beat(CMD_STOP, 16'($urandom));
            add_ticks($urandom_range(30));
          end
        end
      endcase
    end
  endtask

  task automatic drain();
    while (motor_cmds_due.size() != 0 || s_tvalid || timer_updates_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : drive_cmds
    logic       offer;
    motor_cmd_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        timer_updates_due.push_back(predict_timer_update(cmd_t'(s_tuser), s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        offer = motor_cmds_due.size() != 0 && (quiet || $urandom_range(99) >= 17);
        if (offer) begin
          nxt = motor_cmds_due.pop_front();
          s_tuser <= nxt.cmd;
          s_tdata <= nxt.flow;
        end
        s_tvalid <= offer;
      end
    end
  end

  always @(posedge clk) begin : pace_results
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= quiet || $urandom_range(99) >= 17;
    end
  end

  always @(posedge clk) begin : check_updates
    timer_update_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (timer_updates_due.size() == 0) begin
        $display("%0t ns: unexpected result beat, got 0x%0h", $time, m_tdata);
        mismatches++;
      end else begin
        want = timer_updates_due.pop_front();
        results_checked++;
        if (m_tdata[0]) loads_seen++;
        if (m_tdata[33]) halts_seen++;
        check_field("timer_load", {31'd0, want.load}, {31'd0, m_tdata[0]});
        check_field("timer_period", want.period, m_tdata[32:1]);
        check_field("motor_stop", {31'd0, want.halt}, {31'd0, m_tdata[33]});
        check_field("ramp_up_active", {31'd0, want.up}, {31'd0, m_tdata[34]});
        check_field("ramp_down_active", {31'd0, want.down}, {31'd0, m_tdata[35]});
        check_field("target_speed", {15'd0, want.speed}, {15'd0, m_tdata[52:36]});
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_ramp_config(1'b1, 1'b0, 16'd1, 9'd50, 32'd1800000, 32'd144000000);
    add_beat(CMD_START, 16'd0);
    add_beat(CMD_START, 16'd1);
    add_beat(CMD_START, 16'd4000);
    add_beat(CMD_START, 16'd4080);
    add_ticks(3);
    add_beat(CMD_STOP, 16'hA5A5);
    add_ticks(4);
    add_beat(CMD_START, 16'hFFFF);
    add_ticks(10);
    add_beat(CMD_NONE, 16'hFFFF);
    add_beat(CMD_STOP, 16'h5A5A);
    drain();

    set_ramp_config(1'b1, 1'b1, 16'd1, 9'd50, 32'd1800000, 32'd144000000);
    add_ramp_runs(300);
    drain();

    quiet = 1'b1;
    set_ramp_config(1'b0, 1'b0, 16'd3, 9'd400, 32'd1, 32'hFFFF_FFFF);
    add_ramp_runs(200);
    drain();
    quiet = 1'b0;

    set_ramp_config(1'b1, 1'b1, 16'd2, 9'd1, 32'hFFFF_FFFF, 32'd1);
    add_ramp_runs(250);
    drain();

    // zero step rpm; receiver holds off while the sender keeps offering
    set_ramp_config(1'b1, 1'b0, 16'd1, 9'd0, 32'd1800000, 32'd144000000);
    add_ramp_runs(80);
    hold_req = 1'b1;
    drain();

    set_ramp_config(1'b1, 1'b1, 16'd2, 9'd7, $urandom, $urandom);
    add_ramp_runs(220);
    drain();

    set_ramp_config(1'b1, 1'b0, 16'hFFFF, 9'd400, 32'd1800000, 32'd144000000);
    add_ramp_runs(30);
    drain();
    repeat (200) @(posedge clk);

    $display("tb_top: %0d beats sent, %0d results checked (%0d loads, %0d stops)",
             beats_queued, results_checked, loads_seen, halts_seen);
    $display("tb_top: %0d register settings incl. clamp, zero divisor and hold-off",
             settings_used);
    if (mismatches == 0 && timer_updates_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
